### hw/rtl/bru_pkg.sv
// Shared types and constants of the broadcast TV useful bit-rate block.
// Depends on nothing; every other file imports it.
package bru_pkg;

	// Width of a small constant divisor and of its remainder.
	localparam int unsigned DIV_W = 12;
	localparam int unsigned FIN_W = 2;

	// Final scaling selector of one lane.
	localparam logic [FIN_W-1:0] FIN_DVBT      = 2'd0;
	localparam logic [FIN_W-1:0] FIN_ISDB_FULL = 2'd1;
	localparam logic [FIN_W-1:0] FIN_PART_A    = 2'd2;
	localparam logic [FIN_W-1:0] FIN_PART_B    = 2'd3;

	typedef struct packed {
		logic        command;
		logic [13:0] bandwidth_khz;
		logic [1:0]  constellation_a;
		logic [2:0]  coderate_a;
		logic [1:0]  guard_interval;
		logic        partial_mode;
		logic [1:0]  constellation_b;
		logic [2:0]  coderate_b;
	} bru_item_t;

	typedef struct packed {
		logic [31:0] rate_a;
		logic [31:0] rate_b;
		logic        error;
	} bru_result_t;

endpackage

### hw/rtl/bru_cdiv.sv
// Two-stage exact divider of a 32-bit value by a small constant divisor.
// Uses a reciprocal estimate and one correction step; imports bru_pkg.
module bru_cdiv import bru_pkg::*; #(
	parameter int unsigned SIDE_W = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  logic [31:0]       dividend,
	input  logic [31:0]       recip,
	input  logic [DIV_W-1:0]  divisor,
	input  logic [SIDE_W-1:0] side,
	output logic              q_valid,
	output logic [31:0]       quotient,
	output logic [DIV_W-1:0]  remainder,
	output logic [SIDE_W-1:0] q_side
);

	logic [63:0]       prod;
	logic              vld_s1;
	logic [31:0]       x_s1;
	logic [DIV_W-1:0]  d_s1;
	logic [31:0]       q0_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [31:0]       back;
	logic [31:0]       rem0;
	logic [31:0]       rem1;
	logic              ge;
	logic              vld_s2;
	logic [31:0]       q_s2;
	logic [DIV_W-1:0]  r_s2;
	logic [SIDE_W-1:0] side_s2;

	// Estimate: recip = floor(2^32 / d), so the estimate is q or q - 1
	assign prod = 64'(dividend) * 64'(recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= dividend;
		d_s1    <= divisor;
		q0_s1   <= prod[63:32];
		side_s1 <= side;
	end

	// Correction: remainder of the estimate lies below twice the divisor
	assign back = q0_s1 * 32'(d_s1);
	assign rem0 = x_s1 - back;
	assign ge   = rem0 >= 32'(d_s1);
	assign rem1 = ge ? (rem0 - 32'(d_s1)) : rem0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		q_s2    <= q0_s1 + 32'(ge);
		r_s2    <= rem1[DIV_W-1:0];
		side_s2 <= side_s1;
	end

	assign q_valid   = vld_s2;
	assign quotient  = q_s2;
	assign remainder = r_s2;
	assign q_side    = side_s2;

endmodule

### hw/rtl/bru_lane.sv
// One rate lane: raw rate from constellation, guard and code rate, then
// the final segment or TS scaling. Uses bru_cdiv and imports bru_pkg.
module bru_lane import bru_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	input  logic [13:0]      bandwidth_khz,
	input  logic [1:0]       constellation,
	input  logic [2:0]       coderate,
	input  logic [1:0]       guard_interval,
	input  logic [FIN_W-1:0] fin_sel,
	input  logic             tag,
	output logic             rate_valid,
	output logic [31:0]      rate,
	output logic             rate_tag
);

	typedef struct packed {
		logic             bad;
		logic [2:0]       cr;
		logic [FIN_W-1:0] fin;
		logic             tag;
	} side_t;

	typedef struct packed {
		logic        tag;
		logic [31:0] p1;
	} tail_t;

	localparam int unsigned SIDE_W = $bits(side_t);
	localparam int unsigned TAIL_W = $bits(tail_t);

	// Guard fraction divisors 33, 17, 9, 5
	function automatic logic [31:0] gi_recip(input logic [1:0] gi);
		case (gi)
			2'd0:    gi_recip = 32'd130150524;
			2'd1:    gi_recip = 32'd252645135;
			2'd2:    gi_recip = 32'd477218588;
			default: gi_recip = 32'd858993459;
		endcase
	endfunction

	function automatic logic [DIV_W-1:0] gi_div(input logic [1:0] gi);
		case (gi)
			2'd0:    gi_div = 12'd33;
			2'd1:    gi_div = 12'd17;
			2'd2:    gi_div = 12'd9;
			default: gi_div = 12'd5;
		endcase
	endfunction

	// Code rate numerator and divisor; invalid codes are zeroed later
	function automatic logic [2:0] cr_num(input logic [2:0] cr);
		case (cr)
			3'd1:    cr_num = 3'd2;
			3'd2:    cr_num = 3'd3;
			3'd3:    cr_num = 3'd5;
			3'd4:    cr_num = 3'd7;
			default: cr_num = 3'd1;
		endcase
	endfunction

	function automatic logic [31:0] cr_recip(input logic [2:0] cr);
		case (cr)
			3'd1:    cr_recip = 32'd1431655765;
			3'd2:    cr_recip = 32'd1073741824;
			3'd3:    cr_recip = 32'd715827882;
			3'd4:    cr_recip = 32'd536870912;
			default: cr_recip = 32'd2147483648;
		endcase
	endfunction

	function automatic logic [DIV_W-1:0] cr_div(input logic [2:0] cr);
		case (cr)
			3'd1:    cr_div = 12'd3;
			3'd2:    cr_div = 12'd4;
			3'd3:    cr_div = 12'd6;
			3'd4:    cr_div = 12'd8;
			default: cr_div = 12'd2;
		endcase
	endfunction

	// Final scaling: DVB-T 423/544, ISDB-T 188*segments/3213
	function automatic logic [31:0] fin_recip(input logic [FIN_W-1:0] fin);
		case (fin)
			FIN_DVBT: fin_recip = 32'd7895160;
			default:  fin_recip = 32'd1336746;
		endcase
	endfunction

	function automatic logic [DIV_W-1:0] fin_div(input logic [FIN_W-1:0] fin);
		case (fin)
			FIN_DVBT: fin_div = 12'd544;
			default:  fin_div = 12'd3213;
		endcase
	endfunction

	function automatic logic [11:0] fin_mul(input logic [FIN_W-1:0] fin);
		case (fin)
			FIN_DVBT:      fin_mul = 12'd423;
			FIN_ISDB_FULL: fin_mul = 12'd2444;
			FIN_PART_A:    fin_mul = 12'd188;
			default:       fin_mul = 12'd2256;
		endcase
	endfunction

	logic [23:0]       bw_k;
	logic [26:0]       x1;
	logic [31:0]       ng;
	side_t             side_in;
	logic              vld_s1;
	logic [31:0]       ng_s1;
	logic [1:0]        gi_s1;
	side_t             side_s1;

	logic              g_vld;
	logic [31:0]       g_q;
	logic [SIDE_W-1:0] g_side_bits;
	side_t             g_side;
	logic              vld_s4;
	logic [31:0]       nc_s4;
	side_t             side_s4;

	logic              c_vld;
	logic [31:0]       c_q;
	logic [SIDE_W-1:0] c_side_bits;
	side_t             c_side;
	logic [31:0]       raw;

	logic              f_vld;
	logic [31:0]       f_q;
	logic [DIV_W-1:0]  f_r;
	logic [SIDE_W-1:0] f_side_bits;
	side_t             f_side;
	logic [11:0]       f_mul;
	logic [23:0]       p2;
	logic              vld_s9;
	logic [31:0]       p1_s9;
	logic [31:0]       p2_s9;
	logic [FIN_W-1:0]  fin_s9;
	logic              tag_s9;
	tail_t             tail_in;

	logic              w_vld;
	logic [31:0]       w_q;
	logic [TAIL_W-1:0] w_tail_bits;
	tail_t             w_tail;
	logic              vld_s12;
	logic [31:0]       rate_s12;
	logic              tag_s12;

	// Stage 1: bandwidth * 1000 * bits per carrier, then guard numerator
	assign bw_k = 24'(bandwidth_khz) * 24'd1000;

	always_comb begin
		case (constellation)
			2'd0:    x1 = {2'b00, bw_k, 1'b0};
			2'd1:    x1 = {1'b0, bw_k, 2'b00};
			2'd2:    x1 = {1'b0, bw_k, 2'b00} + {2'b00, bw_k, 1'b0};
			default: x1 = '0;
		endcase
		case (guard_interval)
			2'd0:    ng = 32'(x1) << 5;
			2'd1:    ng = 32'(x1) << 4;
			2'd2:    ng = 32'(x1) << 3;
			default: ng = 32'(x1) << 2;
		endcase
	end

	assign side_in.bad = (constellation == 2'd3) || (coderate > 3'd4);
	assign side_in.cr  = coderate;
	assign side_in.fin = fin_sel;
	assign side_in.tag = tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		ng_s1   <= ng;
		gi_s1   <= guard_interval;
		side_s1 <= side_in;
	end

	// Stages 2-3: guard fraction divide
	bru_cdiv #(
		.SIDE_W(SIDE_W)
	) u_div_gi (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (vld_s1),
		.dividend (ng_s1),
		.recip    (gi_recip(gi_s1)),
		.divisor  (gi_div(gi_s1)),
		.side     (side_s1),
		.q_valid  (g_vld),
		.quotient (g_q),
		.remainder(),
		.q_side   (g_side_bits)
	);

	assign g_side = g_side_bits;

	// Stage 4: code rate numerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= g_vld;
		end
	end

	always_ff @(posedge clk) begin
		nc_s4   <= g_q * {29'd0, cr_num(g_side.cr)};
		side_s4 <= g_side;
	end

	// Stages 5-6: code rate divide
	bru_cdiv #(
		.SIDE_W(SIDE_W)
	) u_div_cr (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (vld_s4),
		.dividend (nc_s4),
		.recip    (cr_recip(side_s4.cr)),
		.divisor  (cr_div(side_s4.cr)),
		.side     (side_s4),
		.q_valid  (c_vld),
		.quotient (c_q),
		.remainder(),
		.q_side   (c_side_bits)
	);

	assign c_side = c_side_bits;
	assign raw    = c_side.bad ? 32'd0 : c_q;

	// Stages 7-8: split raw rate into quotient and remainder of the scale divisor
	bru_cdiv #(
		.SIDE_W(SIDE_W)
	) u_div_fin (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (c_vld),
		.dividend (raw),
		.recip    (fin_recip(c_side.fin)),
		.divisor  (fin_div(c_side.fin)),
		.side     (c_side),
		.q_valid  (f_vld),
		.quotient (f_q),
		.remainder(f_r),
		.q_side   (f_side_bits)
	);

	assign f_side = f_side_bits;
	assign f_mul  = fin_mul(f_side.fin);
	assign p2     = 24'(f_r) * 24'(f_mul);

	// Stage 9: (q*D + r)*K/D = q*K + r*K/D
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else begin
			vld_s9 <= f_vld;
		end
	end

	always_ff @(posedge clk) begin
		p1_s9  <= f_q * 32'(f_mul);
		p2_s9  <= 32'(p2);
		fin_s9 <= f_side.fin;
		tag_s9 <= f_side.tag;
	end

	assign tail_in.tag = tag_s9;
	assign tail_in.p1  = p1_s9;

	// Stages 10-11: fractional part divide
	bru_cdiv #(
		.SIDE_W(TAIL_W)
	) u_div_frac (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (vld_s9),
		.dividend (p2_s9),
		.recip    (fin_recip(fin_s9)),
		.divisor  (fin_div(fin_s9)),
		.side     (tail_in),
		.q_valid  (w_vld),
		.quotient (w_q),
		.remainder(),
		.q_side   (w_tail_bits)
	);

	assign w_tail = w_tail_bits;

	// Stage 12: scaled rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else begin
			vld_s12 <= w_vld;
		end
	end

	always_ff @(posedge clk) begin
		rate_s12 <= w_tail.p1 + w_q;
		tag_s12  <= w_tail.tag;
	end

	assign rate_valid = vld_s12;
	assign rate       = rate_s12;
	assign rate_tag   = tag_s12;

endmodule

### hw/rtl/broadcast_tv_useful_bitrate.sv
// Useful transport-stream bit rate of a DVB-T or ISDB-T channel.
// Top level: two bru_lane instances and the packet/error stage; imports bru_pkg.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   busy is held low: the pipeline takes a new item every cycle.
//   item carries the channel parameters; result carries rate_a, rate_b and
//   error. done is high for exactly one cycle with each result, which is
//   taken at the edge that ends that cycle; the receiver cannot stall.
// Throughput and depth:
//   One result per accepted item, one item per cycle. Depth is set by an
//   input register stage, four two-stage constant dividers per lane (guard,
//   code rate, scale split, scale fraction) with a register stage after the
//   guard and the split dividers, a scaled-rate stage and an output register.
// Lanes:
//   Lane A computes DVB-T, full-segment ISDB-T or partial layer A; lane B
//   computes partial layer B. The last stage takes off one TS packet where
//   needed and raises error for invalid or zero rates or rates <= one packet.
// Reset:
//   arst_n clears all valid bits; no result appears until a new item.
module broadcast_tv_useful_bitrate import bru_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  bru_item_t   item,
	output logic        done,
	output bru_result_t result
);

	localparam logic [31:0] PKT_BITS = 32'd1504;
	localparam int unsigned LATENCY  = 13;

	logic             accept;
	logic             part;
	logic [FIN_W-1:0] fin_a;
	logic             a_vld;
	logic [31:0]      sa;
	logic             a_part;
	logic [31:0]      sb;
	bru_result_t      res_d;
	logic             done_q;
	logic             part_q;
	bru_result_t      result_q;

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign part   = item.command & item.partial_mode;

	always_comb begin
		if (!item.command) begin
			fin_a = FIN_DVBT;
		end else if (!item.partial_mode) begin
			fin_a = FIN_ISDB_FULL;
		end else begin
			fin_a = FIN_PART_A;
		end
	end

	// DVB-T / full-segment / layer A
	bru_lane u_lane_a (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (accept),
		.bandwidth_khz (item.bandwidth_khz),
		.constellation (item.constellation_a),
		.coderate      (item.coderate_a),
		.guard_interval(item.guard_interval),
		.fin_sel       (fin_a),
		.tag           (part),
		.rate_valid    (a_vld),
		.rate          (sa),
		.rate_tag      (a_part)
	);

	// Layer B, only meaningful in partial reception
	bru_lane u_lane_b (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (accept),
		.bandwidth_khz (item.bandwidth_khz),
		.constellation (item.constellation_b),
		.coderate      (item.coderate_b),
		.guard_interval(item.guard_interval),
		.fin_sel       (FIN_PART_B),
		.tag           (part),
		.rate_valid    (),
		.rate          (sb),
		.rate_tag      ()
	);

	// Packet subtraction and error flag
	always_comb begin
		res_d = '0;
		if (a_part) begin
			res_d.rate_a = sa;
			res_d.rate_b = sb;
			res_d.error  = (sa == 32'd0) || (sb == 32'd0);
		end else if (sa <= PKT_BITS) begin
			res_d.error  = 1'b1;
		end else begin
			res_d.rate_a = sa - PKT_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= a_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
		part_q   <= a_part;
	end

	assign done   = done_q;
	assign result = result_q;

	// Every accepted transaction gives its result after a fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("result missing after fixed latency");

	// No result without an earlier accepted transaction to match it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without an accepted transaction");

	// A zero rate_a always comes with the error flag
	a_zero_err: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.rate_a == 32'd0)) |-> result.error)
		else $error("zero rate_a without error");

	// rate_b stays zero outside partial reception
	a_rate_b: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !part_q) |-> (result.rate_b == 32'd0))
		else $error("rate_b set outside partial reception");

endmodule
